/* rtl/ibr_pkg.sv */
// Package for the serial-bus frame receiver.
// Holds the request, response and register-index definitions shared by the RTL and checker.
// No dependencies.
package ibr_pkg;

   // Frame geometry.
   localparam int unsigned FRAME_BYTES = 32;
   localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

   // Protocol constants.
   localparam logic [7:0]  HEADER_BYTE  = 8'h20;
   localparam logic [7:0]  COMMAND_BYTE = 8'h40;
   localparam logic [15:0] CHECK_BASE   = 16'hFFFF;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_ENABLE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_ENABLE = 2'd1;

   // Input word: one received byte with its error flag.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_error;
   } req_type;

   // Output word: one replayed frame byte or a status word.
   typedef struct packed {
      logic [7:0] frame_byte;
      logic [4:0] byte_index;
      logic       status;
      logic       last;
   } rsp_type;

endpackage

/* rtl/ibr_ram.sv */
// Generic simple dual-port RAM with a registered read port.
// One write port and one read port; no dependencies.
module ibr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data appears in the cycle after the request and then holds.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ibus_frame_receiver.sv */
// Top level of the serial-bus frame receiver.
// Depends on ibr_pkg and ibr_ram.
//
// The receiver takes one input word per clock while it is idle. A header byte starts a
// 32-byte frame which is written into a 32-entry frame memory while the checksum and the
// command byte are tracked in registers. On the final byte the frame is judged at once: a
// frame with a good command byte and a bad checksum gives one status word, a good frame
// (with forwarding enabled) is replayed from the memory's read port as 32 output words,
// one per cycle while the output is not stalled, after a single priming read. No input
// word is accepted during a replay or while a status word waits to be loaded. The output
// register lets the next input word be accepted while the last output word still waits.
module ibus_frame_receiver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ibr_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ibr_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ibr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ibr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ibr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_STAT  = 4'b0010,
      ST_PRIME = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
   localparam logic [IDX_W-1:0] LOW_IDX  = IDX_W'(FRAME_BYTES - 2);
   localparam logic [IDX_W-1:0] CMD_IDX  = IDX_W'(1);

   state_type        state_ff, state_in;
   logic             rx_enable_ff, rx_enable_in;
   logic             fwd_enable_ff, fwd_enable_in;
   logic             in_frame_ff, in_frame_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [15:0]      sum_ff, sum_in;
   logic             cmd_ok_ff, cmd_ok_in;
   logic [7:0]       low_ff, low_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_fire;
   logic             csr_fire;
   logic             rsp_free;
   logic             wr_en;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic [15:0]      expect_sum;
   logic [15:0]      got_sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checksum comparison on the final byte; that byte is the high half of the word.
   assign expect_sum = CHECK_BASE - sum_ff;
   assign got_sum    = {req_data.rx_byte, low_ff};

   // Frame memory write: header while hunting, any clean byte inside a frame.
   // The count is zero while hunting, so it addresses both cases.
   assign wr_en = req_fire && rx_enable_ff &&
                  ((!in_frame_ff && !req_data.rx_error && req_data.rx_byte == HEADER_BYTE) ||
                   (in_frame_ff && !req_data.rx_error));

   ibr_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff),
      .wr_data (req_data.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Frame collection, configuration and replay sequencing.
   always_comb begin
      state_in      = state_ff;
      rx_enable_in  = rx_enable_ff;
      fwd_enable_in = fwd_enable_ff;
      in_frame_in   = in_frame_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      cmd_ok_in     = cmd_ok_ff;
      low_in        = low_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff;

      // The output word leaves when the sink takes it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes; clearing the receive enable drops any partial frame.
      if (csr_fire) begin
         if (csr_index == CSR_RX_ENABLE) begin
            rx_enable_in = csr_wdata[0];
            if (!csr_wdata[0]) begin
               in_frame_in = 1'b0;
               count_in    = '0;
               sum_in      = '0;
            end
         end else if (csr_index == CSR_FORWARD_ENABLE) begin
            fwd_enable_in = csr_wdata[0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && rx_enable_ff) begin
               if (!in_frame_ff) begin
                  if (!req_data.rx_error && req_data.rx_byte == HEADER_BYTE) begin
                     in_frame_in = 1'b1;
                     count_in    = IDX_W'(1);
                     sum_in      = {8'd0, req_data.rx_byte};
                  end
               end else if (req_data.rx_error) begin
                  in_frame_in = 1'b0;
                  count_in    = '0;
                  sum_in      = '0;
               end else if (count_ff == LAST_IDX) begin
                  // Final byte: judge the frame and resume hunting.
                  in_frame_in = 1'b0;
                  count_in    = '0;
                  sum_in      = '0;
                  if (cmd_ok_ff) begin
                     if (expect_sum != got_sum) begin
                        state_in = ST_STAT;
                     end else if (fwd_enable_ff) begin
                        state_in = ST_PRIME;
                     end
                  end
               end else begin
                  count_in = count_ff + IDX_W'(1);
                  if (count_ff < LOW_IDX) begin
                     sum_in = sum_ff + {8'd0, req_data.rx_byte};
                  end
                  if (count_ff == CMD_IDX) begin
                     cmd_ok_in = (req_data.rx_byte == COMMAND_BYTE);
                  end
                  if (count_ff == LOW_IDX) begin
                     low_in = req_data.rx_byte;
                  end
               end
            end
         end
         ST_STAT: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.frame_byte = '0;
               rsp_data_in.byte_index = '0;
               rsp_data_in.status     = 1'b1;
               rsp_data_in.last       = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         ST_PRIME: begin
            // First read of the replay; its data is ready next cycle.
            rd_en     = 1'b1;
            rd_addr   = '0;
            rd_idx_in = '0;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            // Load the byte on hand and fetch the next one in the same cycle.
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.frame_byte = rd_data;
               rsp_data_in.byte_index = 5'(rd_idx_ff);
               rsp_data_in.status     = 1'b0;
               rsp_data_in.last       = (rd_idx_ff == LAST_IDX);
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = rd_idx_ff + IDX_W'(1);
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rx_enable_ff  <= 1'b0;
         fwd_enable_ff <= 1'b1;
         in_frame_ff   <= 1'b0;
         count_ff      <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rx_enable_ff  <= rx_enable_in;
         fwd_enable_ff <= fwd_enable_in;
         in_frame_ff   <= in_frame_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ok_ff   <= cmd_ok_in;
      low_ff      <= low_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/ibr_checker.sv */
// Port-level checker for the serial-bus frame receiver, with its bind statement.
// Depends on ibr_pkg; attaches to ibus_frame_receiver.
module ibr_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ibr_pkg::rsp_type rsp_data
);
   import ibr_pkg::*;

   // No output word is shown right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output word valid right after reset");

   // A stalled output word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("output word dropped or changed while stalled");

   // A status word is a lone, empty word.
   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.last && rsp_data.frame_byte == 8'd0 && rsp_data.byte_index == 5'd0)
      else $error("malformed status word");

   // Only the final frame byte closes a replay.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.status |->
         (rsp_data.last == (rsp_data.byte_index == 5'(FRAME_BYTES - 1))))
      else $error("last flag does not match the final frame byte");

   // A replayed frame begins with the header and command bytes.
   a_frame_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.status |->
         (rsp_data.byte_index != 5'd0 || rsp_data.frame_byte == HEADER_BYTE) &&
         (rsp_data.byte_index != 5'd1 || rsp_data.frame_byte == COMMAND_BYTE))
      else $error("replayed frame does not start with header and command");

endmodule

bind ibus_frame_receiver ibr_checker u_ibr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* test/tb_top.sv */
// Self-checking testbench for ibus_frame_receiver: directed frames from a table, then random traffic.
// Depends on ibr_pkg and the ibus_frame_receiver RTL; a local predictor builds the expected words.
`timescale 1ns / 100ps

module tb_top;
   import ibr_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_AT        = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_BYTES   = 48;
   localparam logic [5:0] NO_ERR = 6'd63;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 2'd3;
   localparam rsp_type STATUS_WORD = '{frame_byte: 8'h00, byte_index: 5'd0,
                                       status: 1'b1, last: 1'b1};

   typedef enum logic [1:0] {ROW_CSR, ROW_FRAME} row_kind_type;
   typedef enum logic [1:0] {OUT_MODEL, OUT_NONE, OUT_STATUS} row_outcome_type;
   typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_ALT, FILL_RAND} fill_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      logic [7:0]             lead;
      logic [7:0]             cmd;
      fill_type               fill;
      logic                   good_sum;
      logic [5:0]             len;
      logic [5:0]             err_at;
      row_outcome_type        outcome;
   } step_row_type;

   // Directed plan. Columns: kind, csr index, csr data, lead byte, command byte, fill,
   // good checksum, bytes sent, error position, outcome.
   localparam int PLAN_ROWS = 23;
   localparam step_row_type PLAN [PLAN_ROWS] = '{
      // Receiver still off after reset: a header and the start of a frame are ignored.
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_ZERO, 1'b1,
        6'd6, NO_ERR, OUT_NONE},
      '{ROW_CSR, CSR_RX_ENABLE, 8'hFF, 8'h00, 8'h00, FILL_ZERO, 1'b0, 6'd0, NO_ERR, OUT_NONE},
      // Header with a receive error while hunting, then plain noise.
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, 8'h00, FILL_ZERO, 1'b0,
        6'd1, 6'd0, OUT_NONE},
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, 8'hFF, 8'h00, FILL_ZERO, 1'b0, 6'd1, NO_ERR, OUT_NONE},
      // Good frames at the data extremes.
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_ZERO, 1'b1,
        6'd32, NO_ERR, OUT_MODEL},
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_ONES, 1'b1,
        6'd32, NO_ERR, OUT_MODEL},
      // Checksum failure and wrong command byte.
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_RAND, 1'b0,
        6'd32, NO_ERR, OUT_STATUS},
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, 8'h41, FILL_RAND, 1'b1,
        6'd32, NO_ERR, OUT_NONE},
      // Receive errors inside a frame, in the middle and on the final byte.
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_RAND, 1'b1,
        6'd11, 6'd10, OUT_NONE},
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_ALT, 1'b1,
        6'd32, 6'd31, OUT_NONE},
      // Partial frame, then disabling the receiver must throw it away.
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_RAND, 1'b1,
        6'd12, NO_ERR, OUT_NONE},
      '{ROW_CSR, CSR_RX_ENABLE, 8'h02, 8'h00, 8'h00, FILL_ZERO, 1'b0, 6'd0, NO_ERR, OUT_NONE},
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_RAND, 1'b1,
        6'd6, NO_ERR, OUT_NONE},
      '{ROW_CSR, CSR_RX_ENABLE, 8'h01, 8'h00, 8'h00, FILL_ZERO, 1'b0, 6'd0, NO_ERR, OUT_NONE},
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_ALT, 1'b1,
        6'd32, NO_ERR, OUT_MODEL},
      // Forwarding off: a bad frame still reports.
      '{ROW_CSR, CSR_FORWARD_ENABLE, 8'hFE, 8'h00, 8'h00, FILL_ZERO, 1'b0,
        6'd0, NO_ERR, OUT_NONE},
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_RAND, 1'b0,
        6'd32, NO_ERR, OUT_STATUS},
      // Writes to unused indexes change nothing, so a good frame still vanishes.
      '{ROW_CSR, CSR_UNUSED_LO, 8'hFF, 8'h00, 8'h00, FILL_ZERO, 1'b0, 6'd0, NO_ERR, OUT_NONE},
      '{ROW_CSR, CSR_UNUSED_HI, 8'h01, 8'h00, 8'h00, FILL_ZERO, 1'b0, 6'd0, NO_ERR, OUT_NONE},
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_RAND, 1'b1,
        6'd32, NO_ERR, OUT_NONE},
      '{ROW_CSR, CSR_FORWARD_ENABLE, 8'h01, 8'h00, 8'h00, FILL_ZERO, 1'b0,
        6'd0, NO_ERR, OUT_NONE},
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, COMMAND_BYTE, FILL_RAND, 1'b1,
        6'd32, NO_ERR, OUT_MODEL},
      // A second header byte where the command belongs is not a resync.
      '{ROW_FRAME, CSR_RX_ENABLE, 8'h00, HEADER_BYTE, HEADER_BYTE, FILL_RAND, 1'b1,
        6'd32, NO_ERR, OUT_NONE}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state, kept at the block's widths but for the byte count, which has one extra bit.
   logic [7:0]  frame_mem [FRAME_BYTES];
   logic [5:0]  held_count = '0;
   logic [15:0] sum_acc = '0;
   logic        framing = 1'b0;
   logic        rx_on = 1'b0;
   logic        fwd_on = 1'b1;
   bit          typed_outcome = 1'b0;

   rsp_type     pending_words [$];
   rsp_type     want_word;
   logic [7:0]  frame_buf [FRAME_BYTES];
   int          fails = 0;
   int          words_checked = 0;
   int          bytes_sent = 0;
   int          live_bytes = 0;
   int          csr_writes = 0;
   int          stuck_cycles;

   ibus_frame_receiver i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Return the predictor to hunting for a header.
   function automatic void drop_frame();
      framing    = 1'b0;
      held_count = '0;
      sum_acc    = '0;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_RX_ENABLE) begin
         rx_on = data[0];
         if (!rx_on)
            drop_frame();
      end else if (idx == CSR_FORWARD_ENABLE) begin
         fwd_on = data[0];
      end
   endfunction

   // Advance the frame tracker by one received byte and queue the words it yields.
   task automatic track_rx_byte(input req_type w);
      logic [15:0] want_sum;
      logic [15:0] got_sum;
      rsp_type     r;
      int          k;
      if (!rx_on)
         return;
      if (!framing) begin
         if (!w.rx_error && w.rx_byte == HEADER_BYTE) begin
            frame_mem[0] = w.rx_byte;
            sum_acc      = {8'h00, w.rx_byte};
            held_count   = 6'd1;
            framing      = 1'b1;
         end
         return;
      end
      if (w.rx_error) begin
         drop_frame();
         return;
      end
      frame_mem[held_count[4:0]] = w.rx_byte;
      if (held_count < FRAME_BYTES - 2)
         sum_acc = sum_acc + {8'h00, w.rx_byte};
      held_count = held_count + 6'd1;
      if (held_count < FRAME_BYTES)
         return;
      want_sum = CHECK_BASE - sum_acc;
      got_sum  = {frame_mem[FRAME_BYTES-1], frame_mem[FRAME_BYTES-2]};
      drop_frame();
      if (frame_mem[1] != COMMAND_BYTE || typed_outcome)
         return;
      if (want_sum != got_sum) begin
         pending_words.push_back(STATUS_WORD);
         return;
      end
      if (!fwd_on)
         return;
      for (k = 0; k < FRAME_BYTES; k++) begin
         r.frame_byte = frame_mem[k];
         r.byte_index = k[4:0];
         r.status     = 1'b0;
         r.last       = (k == FRAME_BYTES - 1);
         pending_words.push_back(r);
      end
   endtask

   // Build a frame in frame_buf with the chosen fill and a good or broken checksum.
   task automatic fill_frame_buf(input logic [7:0] lead, input logic [7:0] cmd,
                                 input fill_type fill, input logic good_sum);
      logic [15:0] sum;
      logic [15:0] check;
      int          i;
      frame_buf[0] = lead;
      frame_buf[1] = cmd;
      for (i = 2; i < FRAME_BYTES - 2; i++) begin
         case (fill)
            FILL_ZERO: frame_buf[i] = 8'h00;
            FILL_ONES: frame_buf[i] = 8'hFF;
            FILL_ALT:  frame_buf[i] = (i % 2) ? 8'hAA : 8'h55;
            default:   frame_buf[i] = 8'($urandom_range(0, 255));
         endcase
      end
      sum = '0;
      for (i = 0; i < FRAME_BYTES - 2; i++)
         sum = sum + {8'h00, frame_buf[i]};
      check = CHECK_BASE - sum;
      if (!good_sum)
         check[7:0] = check[7:0] ^ 8'($urandom_range(1, 255));
      frame_buf[FRAME_BYTES-2] = check[7:0];
      frame_buf[FRAME_BYTES-1] = check[15:8];
   endtask

   // Offer one word after a random gap (none in a burst) and hold it until the block takes it.
   task automatic send_byte(input req_type w, input bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (rx_on)
         live_bytes++;
      track_rx_byte(w);
   endtask

   task automatic send_sequence(input int len, input int err_at, input bit burst);
      req_type w;
      int      i;
      for (i = 0; i < len; i++) begin
         w.rx_byte  = frame_buf[i];
         w.rx_error = (i == err_at);
         send_byte(w, burst);
      end
   endtask

   // Stop sending, let every expected word drain, and give the block time to settle.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; valid drops for a cycle afterwards so writes never merge.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_csr(idx, data);
      csr_writes++;
      @(posedge clock);
   endtask

   // Result side: random stalls, bursts with no stall, and one long hold-off.
   initial begin
      int stall;
      int burst_left;
      int taken;
      burst_left = 0;
      taken = 0;
      @(posedge clock);
      forever begin
         if (taken == HOLD_AT) begin
            stall = HOLD_CYCLES;
         end else if (burst_left > 0) begin
            stall = 0;
            burst_left--;
         end else begin
            stall = $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0)
               burst_left = $urandom_range(16, 64);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   // Compare every accepted result word with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $error("result word with nothing expected: %p", rsp_data);
            fails++;
         end else begin
            want_word = pending_words.pop_front();
            words_checked++;
            if (rsp_data.frame_byte !== want_word.frame_byte) begin
               $error("frame_byte: expected %0h, got %0h", want_word.frame_byte,
                      rsp_data.frame_byte);
               fails++;
            end
            if (rsp_data.byte_index !== want_word.byte_index) begin
               $error("byte_index: expected %0d, got %0d", want_word.byte_index,
                      rsp_data.byte_index);
               fails++;
            end
            if (rsp_data.status !== want_word.status) begin
               $error("status: expected %0b, got %0b", want_word.status, rsp_data.status);
               fails++;
            end
            if (rsp_data.last !== want_word.last) begin
               $error("last: expected %0b, got %0b", want_word.last, rsp_data.last);
               fails++;
            end
         end
      end
   end

   // Watchdog: too long with no word moving on any channel ends the run.
   initial begin
      stuck_cycles = 0;
      while (stuck_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("Watchdog expired with %0d words still expected.", pending_words.size());
      $display("TB_ERROR");
      $finish;
   end

   // Main sequence: reset, directed table, then random traffic with setting changes.
   initial begin
      step_row_type          cur_row;
      int                    r;
      int                    pick;
      int                    start_live;
      int                    err_at;
      bit                    burst;
      logic [CSR_DATA_W-1:0] data;
      logic [7:0]            cmd;
      req_type               w;
      int                    n;
      int                    i;
      for (i = 0; i < FRAME_BYTES; i++)
         frame_mem[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < PLAN_ROWS; r++) begin
         cur_row = PLAN[r];
         if (cur_row.kind == ROW_CSR) begin
            wait_quiet();
            write_csr(cur_row.csr_idx, cur_row.csr_val);
         end else begin
            fill_frame_buf(cur_row.lead, cur_row.cmd, cur_row.fill, cur_row.good_sum);
            typed_outcome = (cur_row.outcome != OUT_MODEL);
            send_sequence(cur_row.len, (cur_row.err_at == NO_ERR) ? -1 : cur_row.err_at,
                          1'b0);
            if (cur_row.outcome == OUT_STATUS)
               pending_words.push_back(STATUS_WORD);
            typed_outcome = 1'b0;
         end
      end

      // The sender drains fully once more before the random part starts.
      wait_quiet();
      write_csr(CSR_RX_ENABLE, 8'h01);
      start_live = live_bytes;
      while (live_bytes - start_live < RANDOM_BYTES) begin
         if ($urandom_range(0, 9) == 0) begin
            wait_quiet();
            data    = 8'($urandom_range(0, 255));
            data[0] = ($urandom_range(0, 4) != 0);
            write_csr(CSR_RX_ENABLE, data);
            data    = 8'($urandom_range(0, 255));
            write_csr(CSR_FORWARD_ENABLE, data);
            if ($urandom_range(0, 3) == 0)
               write_csr($urandom_range(0, 1) ? CSR_UNUSED_LO : CSR_UNUSED_HI,
                         8'($urandom_range(0, 255)));
         end
         burst = ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 99);
         cmd   = ($urandom_range(0, 9) != 0) ? COMMAND_BYTE : 8'($urandom_range(0, 255));
         if (pick < 70) begin
            // Well-formed frame with random content.
            fill_frame_buf(HEADER_BYTE, cmd, ($urandom_range(0, 7) == 0) ?
                           fill_type'($urandom_range(0, 2)) : FILL_RAND,
                           $urandom_range(0, 3) != 0);
            send_sequence(FRAME_BYTES, -1, burst);
         end else if (pick < 82) begin
            // Frame cut short by a receive error.
            err_at = $urandom_range(1, FRAME_BYTES - 1);
            fill_frame_buf(HEADER_BYTE, cmd, FILL_RAND, 1'b1);
            send_sequence(err_at + 1, err_at, burst);
         end else if (pick < 90) begin
            // Truncated frame; the next sequence's bytes land inside it.
            fill_frame_buf(HEADER_BYTE, cmd, FILL_RAND, 1'b1);
            send_sequence($urandom_range(2, FRAME_BYTES - 1), -1, burst);
         end else begin
            // Line noise with scattered errors and stray header bytes.
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
               w.rx_byte  = ($urandom_range(0, 3) == 0) ? HEADER_BYTE
                                                        : 8'($urandom_range(0, 255));
               w.rx_error = 1'($urandom_range(0, 1));
               send_byte(w, burst);
            end
         end
      end

      wait_quiet();
      $display("Sent %0d bytes (%0d with the receiver on) and checked %0d result words.",
               bytes_sent, live_bytes, words_checked);
      $display("Made %0d register writes covering disable, forwarding off and unused indexes.",
               csr_writes);
      if (fails == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
